[rtl/sbus_frame_pulse_encoder_macros.svh]
// Assertion macros for the frame pulse encoder RTL (included by sfpe_back).
// No dependencies; include by bare file name where checks are written.
`ifndef SBUS_FRAME_PULSE_ENCODER_MACROS_SVH
`define SBUS_FRAME_PULSE_ENCODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFPE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfpe: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SFPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfpe: next-cycle check failed");

`endif

[rtl/sfpe_pkg.sv]
// Shared types, constants and state encodings of the frame pulse encoder.
// No dependencies; imported by the front, back and top-level modules.
`default_nettype none

package sfpe_pkg;

   localparam int NUM_CHANNELS_DEF = 16;
   localparam int CHANNEL_BITS_DEF = 11;

   localparam int VALUE_W     = 13;
   localparam int TICKS_W     = 5;
   localparam int GAP_W       = 16;
   localparam int PULSE_W     = 16;
   localparam int CSR_W       = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int BYTE_W      = 8;
   localparam int CHAN_W      = 11;

   localparam logic [TICKS_W-1:0] BIT_TICKS_RESET = 5'd20;
   localparam logic [GAP_W-1:0]   GAP_TICKS_RESET = 16'd60000;

   localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h0F;
   localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h00;
   localparam int                CHAN_CENTER = 992;
   localparam int                CHAN_MAX    = 2047;

   // value*8/10 = (4*|value|)/5, and x/5 = (x*52429) >> 18 for any 16-bit x
   localparam int              MAG_W       = VALUE_W + 2;
   localparam logic [15:0]     RECIP_5     = 16'd52429;
   localparam int              RECIP_SHIFT = 18;
   localparam int              PROD_W      = MAG_W + 16;
   localparam int              QUOT_W      = 12;
   localparam int              LEVEL_W     = 15;

   localparam logic [1:0] FLAG_CH_A = 2'b01;
   localparam logic [1:0] FLAG_CH_B = 2'b10;

   // start, eight data bits, parity, stop
   localparam int LEVEL_BITS = 11;
   localparam int BIT_IDX_W  = 4;
   localparam int RUN_W      = 10;
   localparam int TRIM_W     = RUN_W + 2;

   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BIT_TICKS = 2'd0,
      CSR_GAP_TICKS = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic              frame_end;
      logic [BYTE_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse_ticks;
      logic               frame_end;
   } result_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_SYNC,
      FR_PACK,
      FR_DRAIN,
      FR_LEFT,
      FR_FLAG,
      FR_ZERO,
      FR_END
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_BITS,
      BK_LAST,
      BK_END_HELD,
      BK_END_GAP
   } back_state_type;

endpackage

`default_nettype wire

[rtl/sfpe_queue.sv]
// Small first-in first-out queue in flip-flops, generic width and depth.
// Depends on nothing; used between front and back and on the result side.
`default_nettype none

module sfpe_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

[rtl/sfpe_front.sv]
// Front end: takes channel beats, scales and packs them, issues byte commands.
// Depends on sfpe_pkg; feeds the command queue read by sfpe_back.
`default_nettype none

module sfpe_front
   import sfpe_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire logic signed [VALUE_W-1:0] value,
   output logic                           full,
   output logic                           cmd_push,
   output cmd_type                        cmd,
   input  wire logic                      cmd_full
);

   localparam int IDX_W  = $clog2(NUM_CHANNELS + 2);
   localparam int ACC_W  = CHANNEL_BITS + BYTE_W - 1;
   localparam int HELD_W = $clog2(ACC_W + 1);

   localparam logic signed [LEVEL_W-1:0] CENTER_S = LEVEL_W'(CHAN_CENTER);
   localparam logic signed [LEVEL_W-1:0] MAX_S    = LEVEL_W'(CHAN_MAX);

   front_state_type    state_ff, state_in;
   logic [IDX_W-1:0]   index_ff, index_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [HELD_W-1:0]  held_ff, held_in;
   logic [1:0]         flags_ff, flags_in;
   logic               pos_ff, pos_in;
   logic               neg_ff, neg_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   logic [VALUE_W-1:0]        value_bits;
   logic [VALUE_W-1:0]        mag;
   logic [MAG_W-1:0]          scaled_mag;
   logic [QUOT_W-1:0]         quot;
   logic signed [LEVEL_W-1:0] quot_s;
   logic signed [LEVEL_W-1:0] level;
   logic [CHAN_W-1:0]         level_clamped;
   logic [CHANNEL_BITS-1:0]   code;

   assign full = (state_ff != FR_IDLE);

   // |value| * 4 times the reciprocal of five
   assign value_bits = value;
   assign mag        = value_bits[VALUE_W-1] ? (~value_bits + VALUE_W'(1)) : value_bits;
   assign scaled_mag = {mag, 2'b00};
   assign prod_in    = PROD_W'(scaled_mag) * PROD_W'(RECIP_5);

   // truncate toward zero, re-center, clamp to the channel range
   assign quot   = prod_ff[RECIP_SHIFT +: QUOT_W];
   assign quot_s = signed'(LEVEL_W'(quot));
   assign level  = neg_ff ? (CENTER_S - quot_s) : (CENTER_S + quot_s);

   always_comb begin
      if (level < 0) begin
         level_clamped = '0;
      end else if (level > MAX_S) begin
         level_clamped = CHAN_W'(CHAN_MAX);
      end else begin
         level_clamped = level[CHAN_W-1:0];
      end
   end

   assign code = level_clamped[CHANNEL_BITS-1:0];

   always_comb begin
      state_in = state_ff;
      index_in = index_ff;
      acc_in   = acc_ff;
      held_in  = held_ff;
      flags_in = flags_ff;
      pos_in   = pos_ff;
      neg_in   = neg_ff;
      cmd_push = 1'b0;
      cmd      = '{frame_end: 1'b0, data: acc_ff[BYTE_W-1:0]};

      unique case (state_ff)
         FR_IDLE: begin
            if (push) begin
               neg_in = value_bits[VALUE_W-1];
               pos_in = !value_bits[VALUE_W-1] && (value_bits != '0);
               if (index_ff == '0) begin
                  state_in = FR_SYNC;
               end else if (index_ff < IDX_W'(NUM_CHANNELS)) begin
                  state_in = FR_PACK;
               end else if (index_ff == IDX_W'(NUM_CHANNELS)) begin
                  state_in = FR_LEFT;
               end else begin
                  state_in = FR_FLAG;
               end
            end
         end
         FR_SYNC: begin
            if (!cmd_full) begin
               cmd_push = 1'b1;
               cmd.data = SYNC_BYTE;
               state_in = FR_PACK;
            end
         end
         FR_PACK: begin
            acc_in   = acc_ff | (ACC_W'(code) << held_ff);
            held_in  = held_ff + HELD_W'(CHANNEL_BITS);
            state_in = FR_DRAIN;
         end
         FR_DRAIN: begin
            if (held_ff >= HELD_W'(BYTE_W)) begin
               if (!cmd_full) begin
                  cmd_push = 1'b1;
                  acc_in   = acc_ff >> BYTE_W;
                  held_in  = held_ff - HELD_W'(BYTE_W);
               end
            end else begin
               index_in = index_ff + IDX_W'(1);
               state_in = FR_IDLE;
            end
         end
         FR_LEFT: begin
            // pad leftover bits into one last byte
            if (held_ff == '0 || !cmd_full) begin
               cmd_push = (held_ff != '0);
               acc_in   = '0;
               held_in  = '0;
               flags_in = flags_ff | (pos_ff ? FLAG_CH_A : 2'b00);
               index_in = index_ff + IDX_W'(1);
               state_in = FR_IDLE;
            end
         end
         FR_FLAG: begin
            if (!cmd_full) begin
               cmd_push = 1'b1;
               cmd.data = {6'b0, flags_ff | (pos_ff ? FLAG_CH_B : 2'b00)};
               state_in = FR_ZERO;
            end
         end
         FR_ZERO: begin
            if (!cmd_full) begin
               cmd_push = 1'b1;
               cmd.data = ZERO_BYTE;
               state_in = FR_END;
            end
         end
         FR_END: begin
            if (!cmd_full) begin
               cmd_push = 1'b1;
               cmd      = '{frame_end: 1'b1, data: ZERO_BYTE};
               flags_in = '0;
               index_in = '0;
               state_in = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         index_ff <= '0;
         acc_ff   <= '0;
         held_ff  <= '0;
         flags_ff <= '0;
      end else begin
         state_ff <= state_in;
         index_ff <= index_in;
         acc_ff   <= acc_in;
         held_ff  <= held_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      neg_ff <= neg_in;
      if (state_ff == FR_IDLE) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

[rtl/sfpe_back.sv]
// Back end: serializes byte commands into trimmed level runs and the frame gap.
// Depends on sfpe_pkg and the assertion macros header.
`default_nettype none
`include "sbus_frame_pulse_encoder_macros.svh"

module sfpe_back
   import sfpe_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [TICKS_W-1:0] bit_ticks,
   input  wire logic [GAP_W-1:0]   gap_ticks,
   input  wire logic               cmd_empty,
   input  cmd_type                 cmd,
   output logic                    cmd_pop,
   input  wire logic               res_full,
   output logic                    res_push,
   output result_type              res
);

   localparam logic [BIT_IDX_W-1:0] LAST_IDX = BIT_IDX_W'(LEVEL_BITS - 1);
   localparam logic signed [TRIM_W-1:0] TRIM_ODD  = TRIM_W'(1);
   localparam logic signed [TRIM_W-1:0] TRIM_EVEN = -TRIM_W'(3);
   localparam logic signed [TRIM_W-1:0] TRIM_MIN  = TRIM_W'(1);

   back_state_type          state_ff, state_in;
   logic [LEVEL_BITS-1:0]   levels_ff, levels_in;
   logic [BIT_IDX_W-1:0]    bit_idx_ff, bit_idx_in;
   logic                    cur_ff, cur_in;
   logic [RUN_W-1:0]        run_ff, run_in;
   logic                    parity_ff, parity_in;
   logic                    held_valid_ff, held_valid_in;
   logic [PULSE_W-1:0]      held_ff, held_in;

   logic [RUN_W-1:0]        bt_run;
   logic [RUN_W-1:0]        run_sel;
   logic signed [TRIM_W-1:0] trimmed;
   logic [PULSE_W-1:0]      new_pulse;
   logic                    level_bit;
   logic                    stall;
   logic                    do_run;
   logic                    step;

   assign bt_run    = RUN_W'(bit_ticks);
   assign run_sel   = (state_ff == BK_LAST) ? (run_ff + bt_run) : run_ff;
   assign trimmed   = signed'(TRIM_W'(run_sel)) + (parity_ff ? TRIM_ODD : TRIM_EVEN);
   assign new_pulse = (trimmed < TRIM_MIN) ? PULSE_W'(1) : PULSE_W'(trimmed[TRIM_W-2:0]);
   assign level_bit = levels_ff[bit_idx_ff];
   // a run can only close while the previous pulse has somewhere to go
   assign stall     = held_valid_ff && res_full;

   always_comb begin
      state_in      = state_ff;
      levels_in     = levels_ff;
      bit_idx_in    = bit_idx_ff;
      cur_in        = cur_ff;
      run_in        = run_ff;
      parity_in     = parity_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      cmd_pop       = 1'b0;
      res_push      = 1'b0;
      res           = '{pulse_ticks: held_ff, frame_end: 1'b0};
      do_run        = 1'b0;
      step          = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd.frame_end) begin
                  state_in = BK_END_HELD;
               end else begin
                  levels_in  = {1'b1, ^cmd.data, cmd.data, 1'b0};
                  cur_in     = 1'b0;
                  run_in     = bt_run;
                  bit_idx_in = BIT_IDX_W'(1);
                  state_in   = BK_BITS;
               end
            end
         end
         BK_BITS: begin
            if (level_bit == cur_ff) begin
               run_in = run_ff + bt_run;
               step   = 1'b1;
            end else if (!stall) begin
               do_run = 1'b1;
               run_in = bt_run;
               cur_in = level_bit;
               step   = 1'b1;
            end
            if (step) begin
               if (bit_idx_ff == LAST_IDX) begin
                  state_in = BK_LAST;
               end else begin
                  bit_idx_in = bit_idx_ff + BIT_IDX_W'(1);
               end
            end
         end
         BK_LAST: begin
            // stop level runs one extra bit time
            if (!stall) begin
               do_run   = 1'b1;
               state_in = BK_IDLE;
            end
         end
         BK_END_HELD: begin
            // odd pulse count: flush held pulse; even: gap replaces it
            if (parity_ff && held_valid_ff) begin
               if (!res_full) begin
                  res_push = 1'b1;
                  state_in = BK_END_GAP;
               end
            end else begin
               state_in = BK_END_GAP;
            end
         end
         BK_END_GAP: begin
            if (!res_full) begin
               res_push      = 1'b1;
               res           = '{pulse_ticks: gap_ticks, frame_end: 1'b1};
               held_valid_in = 1'b0;
               parity_in     = 1'b0;
               state_in      = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (do_run) begin
         res_push      = held_valid_ff;
         held_in       = new_pulse;
         held_valid_in = 1'b1;
         parity_in     = !parity_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         parity_ff     <= 1'b0;
         held_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         parity_ff     <= parity_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      levels_ff  <= levels_in;
      bit_idx_ff <= bit_idx_in;
      cur_ff     <= cur_in;
      run_ff     <= run_in;
      held_ff    <= held_in;
   end

   `SFPE_ASSERT_NEXT(a_gap_clears_hold, clock, reset, (state_ff == BK_END_GAP) && res_push, !held_valid_ff && !parity_ff)
   `SFPE_ASSERT_NOW(a_pulse_from_hold, clock, reset, res_push && !res.frame_end, held_valid_ff)
   `SFPE_ASSERT_NOW(a_bit_idx_range, clock, reset, state_ff == BK_BITS, (bit_idx_ff != '0) && (bit_idx_ff <= LAST_IDX))

endmodule

`default_nettype wire

[rtl/sbus_frame_pulse_encoder.sv]
// Serial frame pulse encoder top level: config registers, front, back, queues.
// Depends on sfpe_pkg, sfpe_queue, sfpe_front and sfpe_back.
//
// Usage:
//   Channel values go in on the req_ side one beat per channel, channels 0 up
//   to NUM_CHANNELS+1 per frame; a beat is taken when req_push is high and
//   req_full is low. Level runs come out on the rsp_ side as a queue: a beat
//   is on rsp_pulse_ticks/rsp_frame_end while rsp_empty is low and leaves when
//   rsp_pop is high. The last beat of each frame carries rsp_frame_end and the
//   inter-frame gap length.
//   The front end accepts and multiplies a channel beat, packs it, issues
//   its bytes one by one and closes. The serializer sets the pace: for each
//   byte it loads the levels, takes ten level steps and closes the stop run;
//   at a frame end it flushes the held pulse on an odd count, then the gap.
//   Reset clears the frame position, packing state and held pulse, and loads
//   bit_ticks with 20 and gap_ticks with 60000. Write csr_ registers only
//   while the encoder is quiet. When the receiver stops popping, the result
//   queue fills, the serializer holds, the command queue fills and req_full
//   stays high until room frees up; nothing is dropped.
`default_nettype none

module sbus_frame_pulse_encoder
   import sfpe_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // channel beats
   input  wire logic                      req_push,
   output logic                           req_full,
   input  wire logic signed [VALUE_W-1:0] req_channel_value,
   // pulse beats
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output logic [PULSE_W-1:0]             rsp_pulse_ticks,
   output logic                           rsp_frame_end,
   // register writes
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CSR_W-1:0]          csr_wdata
);

   logic [TICKS_W-1:0] bit_ticks_ff, bit_ticks_in;
   logic [GAP_W-1:0]   gap_ticks_ff, gap_ticks_in;

   logic       cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type    cmd_wr, cmd_rd;
   logic       res_push, res_full;
   result_type res_wr, res_rd;

   // Register writes: unknown indexes fall through and change nothing.
   always_comb begin
      bit_ticks_in = bit_ticks_ff;
      gap_ticks_in = gap_ticks_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BIT_TICKS: bit_ticks_in = csr_wdata[TICKS_W-1:0];
            CSR_GAP_TICKS: gap_ticks_in = csr_wdata[GAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff <= BIT_TICKS_RESET;
         gap_ticks_ff <= GAP_TICKS_RESET;
      end else begin
         bit_ticks_ff <= bit_ticks_in;
         gap_ticks_ff <= gap_ticks_in;
      end
   end

   // Front end: classify each channel beat and turn it into byte commands.
   sfpe_front #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .value    (req_channel_value),
      .full     (req_full),
      .cmd_push (cmd_push),
      .cmd      (cmd_wr),
      .cmd_full (cmd_full)
   );

   // Decouple the packer from the serializer.
   sfpe_queue #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wr),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rd),
      .empty (cmd_empty)
   );

   // Back end: serialize bytes into trimmed runs, hold one back for the gap.
   sfpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .bit_ticks (bit_ticks_ff),
      .gap_ticks (gap_ticks_ff),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_rd),
      .cmd_pop   (cmd_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res_wr)
   );

   // Result queue parts the serializer from the receiver's stalls.
   sfpe_queue #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_wr),
      .full  (res_full),
      .pop   (rsp_pop && !rsp_empty),
      .rdata (res_rd),
      .empty (rsp_empty)
   );

   assign rsp_pulse_ticks = res_rd.pulse_ticks;
   assign rsp_frame_end   = res_rd.frame_end;

endmodule

`default_nettype wire

[dv/tb_sbus_frame_pulse_encoder.sv]
`timescale 1ns / 100ps
// Self-checking bench for sbus_frame_pulse_encoder: streams frames of channel beats,
// predicts every level-run beat and checks each one in order. Depends on sfpe_pkg
// and the encoder RTL; a driver and a monitor run as clocked processes.
module tb_sbus_frame_pulse_encoder;
   import sfpe_pkg::*;

   localparam int FRAME_LEN    = NUM_CHANNELS_DEF + 2;
   localparam int DRAIN_CYCLES = 64;    // settle time after the last expected beat
   localparam int STALL_LIMIT  = 4000;  // cycles with no beat moving anywhere
   localparam int HOLD_AT_BEAT = 300;   // result beat count after which the long hold-off starts
   localparam int HOLD_CYCLES  = 500;
   localparam int MAX_REPORTS  = 20;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic signed [VALUE_W-1:0] req_channel_value = '0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic [PULSE_W-1:0]        rsp_pulse_ticks;
   logic                      rsp_frame_end;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = CSR_BIT_TICKS;
   logic [CSR_W-1:0]          csr_wdata = '0;

   sbus_frame_pulse_encoder DUT (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_channel_value (req_channel_value),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pulse_ticks   (rsp_pulse_ticks),
      .rsp_frame_end     (rsp_frame_end),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Encoder prediction: own copy of registers and frame state
   // ------------------------------------------------------------------
   logic [TICKS_W-1:0] cfg_bit_ticks;
   logic [GAP_W-1:0]   cfg_gap_ticks;
   int                 frame_pos;
   int unsigned        pack_acc;
   int                 pack_bits;
   bit                 run_odd;       // parity of the pulse count so far in the frame
   logic [PULSE_W-1:0] held_ticks;    // newest run, held back one step
   bit                 held_live;
   logic [1:0]         frame_flags;

   result_type         pulse_q[$];    // expected pulse beats, oldest first
   logic [VALUE_W-1:0] pending_values[$];

   int  fail_count = 0;
   bit  steady = 1'b0;                // no random idles on either side while set

   task automatic emit_beat(logic [PULSE_W-1:0] ticks, logic last);
      result_type beat;
      beat.pulse_ticks = ticks;
      beat.frame_end   = last;
      pulse_q.push_back(beat);
   endtask

   // Trim a finished run, release the previously held one, hold this one.
   task automatic close_run(int run);
      int trimmed;
      trimmed = run + (run_odd ? 1 : -3);
      if (trimmed < 1)
         trimmed = 1;
      if (trimmed > 65535)
         trimmed = 65535;
      if (held_live)
         emit_beat(held_ticks, 1'b0);
      held_ticks = 16'(trimmed);
      held_live  = 1'b1;
      run_odd    = !run_odd;
   endtask

   // Start bit, eight data bits LSB first, even parity, stop lasting two bit times.
   task automatic serialize_byte(logic [BYTE_W-1:0] data);
      logic [10:0] levels;
      logic        cur;
      int          run;
      int          i;
      levels[0]   = 1'b0;
      levels[8:1] = data;
      levels[9]   = ^data;
      levels[10]  = 1'b1;
      cur = 1'b0;
      run = cfg_bit_ticks;
      for (i = 1; i < LEVEL_BITS; i++) begin
         if (levels[i] == cur) begin
            run += cfg_bit_ticks;
         end else begin
            close_run(run);
            run = cfg_bit_ticks;
            cur = levels[i];
         end
      end
      close_run(run + cfg_bit_ticks);
   endtask

   task automatic encode_channel(logic signed [VALUE_W-1:0] value);
      int v;
      int scaled;
      v = value;
      if (frame_pos == 0) begin
         pack_acc    = 0;
         pack_bits   = 0;
         run_odd     = 1'b0;
         held_live   = 1'b0;
         held_ticks  = '0;
         frame_flags = '0;
         serialize_byte(SYNC_BYTE);
      end
      if (frame_pos < NUM_CHANNELS_DEF) begin
         // signed division truncates toward zero, as the encoder scales
         scaled = (v * 8) / 10 + CHAN_CENTER;
         if (scaled < 0)
            scaled = 0;
         if (scaled > CHAN_MAX)
            scaled = CHAN_MAX;
         pack_acc  |= (scaled & ((1 << CHANNEL_BITS_DEF) - 1)) << pack_bits;
         pack_bits += CHANNEL_BITS_DEF;
         while (pack_bits >= 8) begin
            serialize_byte(pack_acc[7:0]);
            pack_acc  >>= 8;
            pack_bits -= 8;
         end
         frame_pos++;
      end else if (frame_pos == NUM_CHANNELS_DEF) begin
         // flush leftover packed bits as one zero-padded byte
         if (pack_bits > 0) begin
            serialize_byte(pack_acc[7:0]);
            pack_acc  = 0;
            pack_bits = 0;
         end
         if (v > 0)
            frame_flags |= FLAG_CH_A;
         frame_pos++;
      end else begin
         if (v > 0)
            frame_flags |= FLAG_CH_B;
         serialize_byte({6'b0, frame_flags});
         serialize_byte(ZERO_BYTE);
         // odd pulse count: release the held run before the gap; even: gap replaces it
         if (run_odd && held_live)
            emit_beat(held_ticks, 1'b0);
         emit_beat(cfg_gap_ticks, 1'b1);
         held_live  = 1'b0;
         held_ticks = '0;
         frame_pos  = 0;
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: offer pending channel values; outside steady phases, idle at random after each beat
   // ------------------------------------------------------------------
   int send_wait = 0;
   bit push_next;

   always @(posedge clock) begin
      if (reset) begin
         req_push  <= 1'b0;
         send_wait = 0;
      end else begin
         push_next = req_push;
         if (req_push && !req_full) begin
            encode_channel(req_channel_value);
            send_wait = steady ? 0 : $urandom_range(0, 4);
            push_next = 1'b0;
         end
         // hold push and value while the block is full; advance only after a beat
         if (!push_next) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (pending_values.size() > 0) begin
               req_channel_value <= pending_values.pop_front();
               push_next = 1'b1;
            end
         end
         req_push <= push_next;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: pop result beats with random stalls, one long hold-off
   // ------------------------------------------------------------------
   int         recv_wait = 0;
   int         hold_left = 0;
   int         beats_out = 0;
   bit         hold_done = 1'b0;
   bit         pop_next;
   result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop   <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pulse_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: pulse beat with nothing expected: ticks %0d frame_end %0b",
                           $time, rsp_pulse_ticks, rsp_frame_end);
            end else begin
               want = pulse_q.pop_front();
               if (want.pulse_ticks !== rsp_pulse_ticks ||
                   want.frame_end !== rsp_frame_end) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("%0t: pulse beat mismatch: expected ticks %0d frame_end %0b, actual ticks %0d frame_end %0b",
                              $time, want.pulse_ticks, want.frame_end,
                              rsp_pulse_ticks, rsp_frame_end);
               end
            end
            beats_out++;
            recv_wait = steady ? 0 : $urandom_range(0, 4);
            // stop popping long enough for both queues to fill and req_full to rise;
            // start only while the sender still has beats to offer
            if (!hold_done && beats_out >= HOLD_AT_BEAT && pending_values.size() > 0) begin
               hold_left = HOLD_CYCLES;
               hold_done = 1'b1;
            end
         end
         pop_next = 1'b1;
         if (hold_left > 0) begin
            hold_left--;
            pop_next = 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            pop_next = 1'b0;
         end
         rsp_pop <= pop_next;
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run if no beat moves for too long
   // ------------------------------------------------------------------
   int stall_count = 0;

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_write) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
         $display("sbus_frame_pulse_encoder regression: fail");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus sequencing
   // ------------------------------------------------------------------
   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_BIT_TICKS)
         cfg_bit_ticks = data[TICKS_W-1:0];
      else
         cfg_gap_ticks = data[GAP_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Wait for the last expected beat, then let the pipeline settle.
   task automatic wait_quiet();
      while (pending_values.size() != 0 || req_push || pulse_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mix of full-range values, clamp edges and small values around zero.
   function automatic logic [VALUE_W-1:0] draw_channel(int pos);
      int pick;
      int v;
      pick = $urandom_range(0, 9);
      if (pos >= NUM_CHANNELS_DEF && pick < 5)
         v = int'($urandom_range(0, 2)) - 1;
      else if (pick < 4)
         v = int'($urandom_range(0, 8191));
      else if (pick < 6)
         v = int'($urandom_range(0, 24)) - 1254;
      else if (pick < 8)
         v = int'($urandom_range(0, 24)) + 1308;
      else
         v = int'($urandom_range(0, 20)) - 10;
      return VALUE_W'(v);
   endfunction

   task automatic queue_frame();
      int pos;
      for (pos = 0; pos < FRAME_LEN; pos++)
         pending_values.push_back(draw_channel(pos));
   endtask

   initial begin
      // full-scale ends, clamp thresholds, truncation toward zero, bit patterns, flags
      int corner_values [FRAME_LEN] = '{-4096, 4095, 0, -1, 1, -3, -1240, -1242,
                                        1319, 1320, 2730, -2731, 7, -7, 1000, -1000,
                                        1, 0};
      int          pos;
      int          phase;
      logic [4:0]  bt;
      logic [15:0] gap;

      cfg_bit_ticks = BIT_TICKS_RESET;
      cfg_gap_ticks = GAP_TICKS_RESET;
      frame_pos     = 0;
      pack_acc      = 0;
      pack_bits     = 0;
      run_odd       = 1'b0;
      held_ticks    = '0;
      held_live     = 1'b0;
      frame_flags   = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed frame under reset register values
      for (pos = 0; pos < FRAME_LEN; pos++)
         pending_values.push_back(VALUE_W'(corner_values[pos]));
      wait_quiet();

      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               bt  = 5'd4;
               gap = 16'd1;
            end
            1: begin
               bt  = 5'd21;
               gap = 16'hFFFF;
            end
            2: begin
               bt  = 5'd0;
               gap = 16'd0;
            end
            3: begin
               bt  = 5'd31;
               gap = 16'($urandom_range(1, 65535));
            end
            default: begin
               bt  = 5'($urandom_range(4, 21));
               gap = 16'($urandom_range(1, 65535));
            end
         endcase
         steady = (phase % 2 == 1);
         // upper data bits are don't-care for the tick register; drive them random
         write_csr(CSR_BIT_TICKS, (16'($urandom) & 16'hFFE0) | {11'b0, bt});
         write_csr(CSR_GAP_TICKS, gap);
         queue_frame();
         if (phase == 6)
            queue_frame();
         wait_quiet();
      end

      if (fail_count == 0)
         $display("sbus_frame_pulse_encoder regression: pass");
      else
         $display("sbus_frame_pulse_encoder regression: fail");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/sfpe_pkg.sv
rtl/sfpe_queue.sv
rtl/sfpe_front.sv
rtl/sfpe_back.sv
rtl/sbus_frame_pulse_encoder.sv
dv/tb_sbus_frame_pulse_encoder.sv
